FILE: src/irpp_pkg.sv
// Shared types and constants of the iRPROP+ update engine.
package irpp_pkg;

  localparam int IDX_W    = 10;
  localparam int WEIGHT_W = 32;
  localparam int STEP_W   = 31;
  localparam int INC_W    = 16;
  localparam int DEC_W    = 15;
  localparam int PROD_W   = STEP_W + INC_W;
  localparam int FRAC_SH  = 14;
  localparam int CFG_W    = 31;

  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_LOAD   = 1'b1;

  localparam logic [1:0] SIGN_ZERO = 2'd0;
  localparam logic [1:0] SIGN_POS  = 2'd1;
  localparam logic [1:0] SIGN_NEG  = 2'd2;

  localparam logic [1:0] CFG_INCREASE = 2'd0;
  localparam logic [1:0] CFG_DECREASE = 2'd1;
  localparam logic [1:0] CFG_STEP_MIN = 2'd2;
  localparam logic [1:0] CFG_STEP_MAX = 2'd3;

  localparam logic [STEP_W-1:0]   STEP_CAP   = {STEP_W{1'b1}};
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_GROW,
    KIND_SHRINK
  } upd_kind_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [STEP_W-1:0]   step;
    logic [WEIGHT_W-1:0] last_delta;
    logic [1:0]          sign;
  } entry_t;

  typedef struct packed {
    logic      is_load;
    logic      in_range;
    upd_kind_t kind;
    logic      grad_pos;
    logic      grad_neg;
    logic      worse;
  } stage_ctl_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [STEP_W-1:0]   step;
    logic                sat;
  } result_t;

endpackage

FILE: src/irpp_if.sv
// Handshake channels for update/load transactions and their results.
interface irpp_in_if;
  import irpp_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [IDX_W-1:0]           entry_index;
  logic signed [WEIGHT_W-1:0] gradient;
  logic signed [WEIGHT_W-1:0] load_weight;
  logic [STEP_W-1:0]          load_step;
  logic [31:0]                loss_now;
  logic [31:0]                loss_before;

  modport source (output valid, func, entry_index, gradient, load_weight, load_step,
                  loss_now, loss_before, input ready);
  modport sink (input valid, func, entry_index, gradient, load_weight, load_step,
                loss_now, loss_before, output ready);
endinterface

interface irpp_out_if;
  import irpp_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [IDX_W-1:0]           result_index;
  logic signed [WEIGHT_W-1:0] new_weight;
  logic [STEP_W-1:0]          new_step;
  logic                       weight_saturated;

  modport source (output valid, result_index, new_weight, new_step, weight_saturated,
                  input ready);
  modport sink (input valid, result_index, new_weight, new_step, weight_saturated,
                output ready);
endinterface

FILE: src/irpp_store.sv
// Parameter entry memory: one write port, one registered read port.
module irpp_store
  import irpp_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-before-write; same-edge writes are caught by the forwarding register
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/irpp_update.sv
// Second stage: step clamp, delta select, saturating weight add, new entry (or the loaded entry on a load).
module irpp_update
  import irpp_pkg::*;
(
  input  stage_ctl_t          ctl,
  input  entry_t              rec,
  input  logic [PROD_W-1:0]   product,
  input  logic [WEIGHT_W-1:0] load_weight,
  input  logic [STEP_W-1:0]   load_step,
  input  logic [STEP_W-1:0]   step_minimum,
  input  logic [STEP_W-1:0]   step_maximum,
  output entry_t              wr_rec,
  output result_t             res
);

  logic [PROD_W-FRAC_SH-1:0] scaled;
  logic [STEP_W-1:0]         capped;
  logic [STEP_W-1:0]         step_new;
  logic [WEIGHT_W-1:0]       step_pos;
  logic [WEIGHT_W-1:0]       step_neg;
  logic [WEIGHT_W-1:0]       delta_new;
  logic [WEIGHT_W:0]         addend;
  logic                      do_add;
  logic [1:0]                sign_new;
  logic signed [WEIGHT_W+1:0] sum;
  logic [WEIGHT_W-1:0]       weight_add;
  logic                      ovf;

  assign scaled = product[PROD_W-1:FRAC_SH];
  assign capped = (|scaled[PROD_W-FRAC_SH-1:STEP_W]) ? STEP_CAP : scaled[STEP_W-1:0];

  always_comb begin
    step_new  = rec.step;
    delta_new = rec.last_delta;
    addend    = '0;
    do_add    = 1'b0;
    sign_new  = SIGN_ZERO;
    step_pos  = '0;
    step_neg  = '0;
    unique case (ctl.kind)
      KIND_GROW: begin
        step_new = (capped > step_maximum) ? step_maximum : capped;
      end
      KIND_SHRINK: begin
        step_new = (capped < step_minimum) ? step_minimum : capped;
      end
      default: begin
        step_new = rec.step;
      end
    endcase
    step_pos = {1'b0, step_new};
    step_neg = ~{1'b0, step_new} + 1'b1;
    if (ctl.kind == KIND_SHRINK) begin
      // undo the previous move when the loss got worse
      addend = ~{rec.last_delta[WEIGHT_W-1], rec.last_delta} + 1'b1;
      do_add = ctl.worse;
    end else begin
      // weight moves against the gradient
      if (ctl.grad_pos) begin
        delta_new = step_neg;
        sign_new  = SIGN_POS;
      end else if (ctl.grad_neg) begin
        delta_new = step_pos;
        sign_new  = SIGN_NEG;
      end else begin
        delta_new = '0;
      end
      addend = {delta_new[WEIGHT_W-1], delta_new};
      do_add = 1'b1;
    end
  end

  assign sum = $signed({{2{rec.weight[WEIGHT_W-1]}}, rec.weight})
             + $signed({addend[WEIGHT_W], addend});

  always_comb begin
    ovf        = 1'b0;
    weight_add = sum[WEIGHT_W-1:0];
    if (sum > $signed({2'b00, WEIGHT_MAX})) begin
      ovf        = 1'b1;
      weight_add = WEIGHT_MAX;
    end else if (sum < $signed({2'b11, WEIGHT_MIN})) begin
      ovf        = 1'b1;
      weight_add = WEIGHT_MIN;
    end
  end

  always_comb begin
    if (ctl.is_load) begin
      wr_rec.weight     = load_weight;
      wr_rec.step       = load_step;
      wr_rec.last_delta = '0;
      wr_rec.sign       = SIGN_ZERO;
      res.sat           = 1'b0;
    end else begin
      wr_rec.weight     = do_add ? weight_add : rec.weight;
      wr_rec.step       = step_new;
      wr_rec.last_delta = delta_new;
      wr_rec.sign       = sign_new;
      res.sat           = do_add & ovf;
    end
    res.weight = wr_rec.weight;
    res.step   = wr_rec.step;
  end

endmodule

FILE: src/irprop_plus_weight_update_top.sv
// Top level of the iRPROP+ per-parameter weight update engine.
// An accepted transaction passes through stage A, stage B and the output register in turn.
// Throughput: one transaction per cycle while the output is not stalled; a transaction that
//   follows one to the same entry waits in stage A for the entry write-back (interlock).
// Reset: clears pipeline valids and loads the config registers with their defaults; the entry
//   memory is not cleared and needs no clearing pass if the user loads every entry before use.
module irprop_plus_weight_update_top
  import irpp_pkg::*;
#(
  parameter int NUM_ENTRIES = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  irpp_in_if.sink           items,
  irpp_out_if.source        results
);

  // Memory only needs the entries a 10-bit index can reach.
  localparam int DEPTH = (NUM_ENTRIES < (1 << IDX_W)) ? NUM_ENTRIES : (1 << IDX_W);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // ---------------- configuration registers ----------------
  logic [INC_W-1:0]  increase_factor;
  logic [DEC_W-1:0]  decrease_factor;
  logic [STEP_W-1:0] step_minimum;
  logic [STEP_W-1:0] step_maximum;

  always_ff @(posedge clk) begin
    if (rst) begin
      increase_factor <= INC_W'(19661);
      decrease_factor <= DEC_W'(8192);
      step_minimum    <= STEP_W'(17);
      step_maximum    <= STEP_W'(838860800);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INCREASE: increase_factor <= cfg_data[INC_W-1:0];
        CFG_DECREASE: decrease_factor <= cfg_data[DEC_W-1:0];
        CFG_STEP_MIN: step_minimum    <= cfg_data[STEP_W-1:0];
        CFG_STEP_MAX: step_maximum    <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // Stage A: memory read data arrives, sign compare, step * factor.
  // Stage B: clamp, saturating weight add, write-back into memory.
  // Stage O: output register holding the result transaction.
  logic                a_valid;
  logic                a_func;
  logic [IDX_W-1:0]    a_idx;
  logic [WEIGHT_W-1:0] a_grad;
  logic                a_worse;
  logic                a_in_range;
  logic [WEIGHT_W-1:0] a_load_weight;
  logic [STEP_W-1:0]   a_load_step;
  logic                a_fwd_valid;
  entry_t              a_fwd_rec;
  entry_t              rd_data;
  entry_t              a_rec;

  logic                b_valid;
  stage_ctl_t          b_ctl;
  logic [IDX_W-1:0]    b_idx;
  entry_t              b_rec;
  logic [PROD_W-1:0]   b_product;
  logic [WEIGHT_W-1:0] b_load_weight;
  logic [STEP_W-1:0]   b_load_step;

  logic                o_valid;
  logic [IDX_W-1:0]    o_index;
  logic [WEIGHT_W-1:0] o_weight;
  logic [STEP_W-1:0]   o_step;
  logic                o_sat;

  logic       in_fire;
  logic       b_move;
  logic       b_free;
  logic       hazard;
  logic       a_move;
  logic       wr_en;
  entry_t     wr_rec;
  result_t    b_res;
  stage_ctl_t a_ctl;
  logic [INC_W-1:0]  factor;
  logic [PROD_W-1:0] a_product;
  logic              grad_pos;
  logic              grad_neg;
  logic              same_sign;
  logic              opp_sign;

  assign b_move  = b_valid && (!o_valid || results.ready);
  assign b_free  = !b_valid || b_move;
  // B has not yet written the entry A wants: hold A until B writes it and catch the write.
  assign hazard  = a_valid && b_valid && b_ctl.in_range && (b_idx == a_idx);
  assign a_move  = a_valid && b_free && !hazard;
  assign items.ready = !a_valid || a_move;
  assign in_fire = items.valid && items.ready;
  assign wr_en   = b_move && b_ctl.in_range;

  // ---------------- entry memory ----------------
  irpp_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (items.entry_index[AW-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (b_idx[AW-1:0]),
    .wr_data (wr_rec)
  );

  // ---------------- stage A ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_fire) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_func        <= items.func;
      a_idx         <= items.entry_index;
      a_grad        <= items.gradient;
      a_worse       <= items.loss_now > items.loss_before;
      a_in_range    <= 32'(items.entry_index) < NUM_ENTRIES;
      a_load_weight <= items.load_weight;
      a_load_step   <= items.load_step;
    end
  end

  // Forwarding: a write to the entry at or after the read edge overrides the memory data.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_fwd_valid <= 1'b0;
    end else if (in_fire) begin
      a_fwd_valid <= wr_en && (b_idx == items.entry_index);
    end else if (wr_en && a_valid && (b_idx == a_idx)) begin
      a_fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      a_fwd_rec <= wr_rec;
    end
  end

  assign a_rec = a_fwd_valid ? a_fwd_rec : rd_data;

  assign grad_pos  = !a_grad[WEIGHT_W-1] && (|a_grad);
  assign grad_neg  = a_grad[WEIGHT_W-1];
  // sign code three reads as zero
  assign same_sign = ((a_rec.sign == SIGN_POS) && grad_pos) ||
                     ((a_rec.sign == SIGN_NEG) && grad_neg);
  assign opp_sign  = ((a_rec.sign == SIGN_POS) && grad_neg) ||
                     ((a_rec.sign == SIGN_NEG) && grad_pos);
  assign factor    = same_sign ? increase_factor : {1'b0, decrease_factor};
  assign a_product = PROD_W'(a_rec.step) * PROD_W'(factor);

  always_comb begin
    a_ctl.is_load  = (a_func == FUNC_LOAD);
    a_ctl.in_range = a_in_range;
    a_ctl.kind     = same_sign ? KIND_GROW : (opp_sign ? KIND_SHRINK : KIND_PLAIN);
    a_ctl.grad_pos = grad_pos;
    a_ctl.grad_neg = grad_neg;
    a_ctl.worse    = a_worse;
  end

  // ---------------- stage B ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_move) begin
      b_valid <= 1'b1;
    end else if (b_move) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_ctl         <= a_ctl;
      b_idx         <= a_idx;
      b_rec         <= a_rec;
      b_product     <= a_product;
      b_load_weight <= a_load_weight;
      b_load_step   <= a_load_step;
    end
  end

  irpp_update u_update (
    .ctl          (b_ctl),
    .rec          (b_rec),
    .product      (b_product),
    .load_weight  (b_load_weight),
    .load_step    (b_load_step),
    .step_minimum (step_minimum),
    .step_maximum (step_maximum),
    .wr_rec       (wr_rec),
    .res          (b_res)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (b_move) begin
      o_valid <= 1'b1;
    end else if (results.ready) begin
      o_valid <= 1'b0;
    end
  end

  // out-of-range index: transaction is dropped, result reads zero
  always_ff @(posedge clk) begin
    if (b_move) begin
      o_index  <= b_idx;
      o_weight <= b_ctl.in_range ? b_res.weight : '0;
      o_step   <= b_ctl.in_range ? b_res.step : '0;
      o_sat    <= b_ctl.in_range && b_res.sat;
    end
  end

  assign results.valid            = o_valid;
  assign results.result_index     = o_index;
  assign results.new_weight       = o_weight;
  assign results.new_step         = o_step;
  assign results.weight_saturated = o_sat;

endmodule

FILE: src/irpp_checker.sv
// Port-level checks of the update engine, bound to the top level.
module irpp_checker
  import irpp_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [IDX_W-1:0]    out_index,
  input logic [WEIGHT_W-1:0] out_weight,
  input logic [STEP_W-1:0]   out_step,
  input logic                out_sat
);

  logic [2:0] pending;
  logic       in_fire;
  logic       out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_fire && !out_fire) begin
      pending <= pending + 3'd1;
    end else if (out_fire && !in_fire) begin
      pending <= pending - 3'd1;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    (out_valid |-> pending != 3'd0) and (pending <= 3'd3))
    else $error("result without accepted transaction or too many in flight");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_sat) |-> (out_weight == WEIGHT_MAX || out_weight == WEIGHT_MIN))
    else $error("saturated weight not at a limit");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_index) &&
      $stable(out_weight) && $stable(out_step) && $stable(out_sat)))
    else $error("stalled result changed");

endmodule

bind irprop_plus_weight_update_top irpp_checker u_irpp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (items.valid),
  .in_ready   (items.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_index  (results.result_index),
  .out_weight (results.new_weight),
  .out_step   (results.new_step),
  .out_sat    (results.weight_saturated)
);

FILE: tb/sv/irpp_update_checker.sv
// Checker for the iRPROP+ update engine: predicts each transaction and compares results.
module irpp_update_checker
  import irpp_pkg::*;
#(
  parameter int NUM_ENTRIES = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  irpp_in_if               items,
  irpp_out_if              results,
  output int               mismatches,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [INC_W-1:0]  RESET_INCREASE = 16'd19661;
  localparam logic [DEC_W-1:0]  RESET_DECREASE = 15'd8192;
  localparam logic [STEP_W-1:0] RESET_STEP_MIN = 31'd17;
  localparam logic [STEP_W-1:0] RESET_STEP_MAX = 31'd838860800;
  localparam longint WEIGHT_TOP    = 64'sd2147483647;
  localparam longint WEIGHT_BOTTOM = -64'sd2147483648;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [IDX_W-1:0]    index;
    logic [WEIGHT_W-1:0] weight;
    logic [STEP_W-1:0]   step;
    logic                sat;
  } update_result_t;

  logic [INC_W-1:0]  grow_factor;
  logic [DEC_W-1:0]  shrink_factor;
  logic [STEP_W-1:0] step_floor;
  logic [STEP_W-1:0] step_ceiling;

  logic signed [WEIGHT_W-1:0] weight_mem [NUM_ENTRIES];
  logic [STEP_W-1:0]          step_mem   [NUM_ENTRIES];
  logic signed [WEIGHT_W-1:0] delta_mem  [NUM_ENTRIES];
  logic [1:0]                 sign_mem   [NUM_ENTRIES];

  update_result_t pending_results [$];

  // Step times Q2.14 factor, truncated, capped at the 31-bit step range.
  function automatic logic [STEP_W-1:0] scale_step(logic [STEP_W-1:0] step,
                                                   logic [INC_W-1:0] factor);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(step) * PROD_W'(factor);
    prod = prod >> FRAC_SH;
    if (prod > PROD_W'(STEP_CAP)) return STEP_CAP;
    return prod[STEP_W-1:0];
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] add_saturating(
      logic signed [WEIGHT_W-1:0] base, longint delta, output logic clipped);
    longint total;
    total = base + delta;
    clipped = 1'b0;
    if (total > WEIGHT_TOP) begin
      clipped = 1'b1;
      return WEIGHT_TOP[WEIGHT_W-1:0];
    end
    if (total < WEIGHT_BOTTOM) begin
      clipped = 1'b1;
      return WEIGHT_BOTTOM[WEIGHT_W-1:0];
    end
    return total[WEIGHT_W-1:0];
  endfunction

  function automatic update_result_t apply_transaction(
      logic func, logic [IDX_W-1:0] idx, logic signed [WEIGHT_W-1:0] grad,
      logic [WEIGHT_W-1:0] wload, logic [STEP_W-1:0] sload,
      logic [31:0] lnow, logic [31:0] lbefore);
    update_result_t r;
    int gsign;
    int psign;
    logic [STEP_W-1:0] step;
    logic sat;
    longint span;
    r = '0;
    r.index = idx;
    sat = 1'b0;
    if (idx >= NUM_ENTRIES) return r;
    if (func == FUNC_LOAD) begin
      weight_mem[idx] = wload;
      step_mem[idx]   = sload;
      delta_mem[idx]  = '0;
      sign_mem[idx]   = SIGN_ZERO;
    end else begin
      gsign = (grad > 0) ? 1 : ((grad < 0) ? -1 : 0);
      psign = (sign_mem[idx] == SIGN_POS) ? 1 : ((sign_mem[idx] == SIGN_NEG) ? -1 : 0);
      step  = step_mem[idx];
      if (gsign * psign > 0) begin
        step = scale_step(step, grow_factor);
        if (step > step_ceiling) step = step_ceiling;
        step_mem[idx] = step;
        span = {33'b0, step};
        if (gsign > 0) span = -span;
        delta_mem[idx]  = span[WEIGHT_W-1:0];
        weight_mem[idx] = add_saturating(weight_mem[idx], span, sat);
        sign_mem[idx]   = (gsign > 0) ? SIGN_POS : SIGN_NEG;
      end else if (gsign * psign < 0) begin
        step = scale_step(step, {1'b0, shrink_factor});
        if (step < step_floor) step = step_floor;
        step_mem[idx] = step;
        // loss got worse: undo the last move; last delta itself is kept
        if (lnow > lbefore)
          weight_mem[idx] = add_saturating(weight_mem[idx], -longint'(delta_mem[idx]), sat);
        sign_mem[idx] = SIGN_ZERO;
      end else begin
        span = (gsign == 0) ? 64'sd0 : {33'b0, step};
        if (gsign > 0) span = -span;
        delta_mem[idx]  = span[WEIGHT_W-1:0];
        weight_mem[idx] = add_saturating(weight_mem[idx], span, sat);
        sign_mem[idx]   = (gsign > 0) ? SIGN_POS : ((gsign < 0) ? SIGN_NEG : SIGN_ZERO);
      end
    end
    r.weight = weight_mem[idx];
    r.step   = step_mem[idx];
    r.sat    = sat;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [IDX_W-1:0] idx,
                                 logic [63:0] got, logic [63:0] want);
    if (mismatches < PRINT_CAP)
      $display("%0t: %s mismatch, entry %0d: got %h, want %h", $time, field, idx, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    update_result_t want;
    if (rst) begin
      grow_factor   = RESET_INCREASE;
      shrink_factor = RESET_DECREASE;
      step_floor    = RESET_STEP_MIN;
      step_ceiling  = RESET_STEP_MAX;
      mismatches    = 0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INCREASE: grow_factor   = cfg_data[INC_W-1:0];
          CFG_DECREASE: shrink_factor = cfg_data[DEC_W-1:0];
          CFG_STEP_MIN: step_floor    = cfg_data[STEP_W-1:0];
          CFG_STEP_MAX: step_ceiling  = cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (items.valid && items.ready)
        pending_results.push_back(apply_transaction(items.func, items.entry_index,
            items.gradient, items.load_weight, items.load_step,
            items.loss_now, items.loss_before));
      if (results.valid && results.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", results.result_index, '0, '0);
        end else begin
          want = pending_results.pop_front();
          if (results.result_index !== want.index)
            report_mismatch("result_index", want.index, 64'(results.result_index),
                            64'(want.index));
          if (results.new_weight !== want.weight)
            report_mismatch("new_weight", want.index, 64'(results.new_weight),
                            64'(want.weight));
          if (results.new_step !== want.step)
            report_mismatch("new_step", want.index, 64'(results.new_step), 64'(want.step));
          if (results.weight_saturated !== want.sat)
            report_mismatch("weight_saturated", want.index, 64'(results.weight_saturated),
                            64'(want.sat));
        end
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

FILE: tb/sv/tb_irprop_plus_weight_update_top.sv
// Testbench top: stimulus, flow control and verdict for the iRPROP+ update engine.
module tb_irprop_plus_weight_update_top;
  import irpp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ENTRIES = 1024;
  // Receiver hold-off long enough to back the pipeline up into the input.
  localparam int HOLD_CYCLES = 300;
  // Cycles without any transaction before the run is declared hung. The slowest
  // correct stretch is the hold-off plus a sender gap and a mostly-stalled
  // receiver pattern, far below this.
  localparam int STALL_LIMIT = 4000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = CFG_INCREASE;
  logic [CFG_W-1:0] cfg_data = '0;

  irpp_in_if  item_bus ();
  irpp_out_if result_bus ();

  int mismatch_count;
  int results_pending;
  int idle_cycles = 0;

  // sender bookkeeping
  int               burst_left = 0;
  bit               sender_gaps = 1'b1;
  bit               hold_request = 1'b0;
  bit               entry_loaded [NUM_ENTRIES];
  logic [IDX_W-1:0] loaded_list [$];
  logic [IDX_W-1:0] last_index = '0;

  irprop_plus_weight_update_top #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (item_bus),
    .results   (result_bus)
  );

  irpp_update_checker #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .items       (item_bus),
    .results     (result_bus),
    .mismatches  (mismatch_count),
    .outstanding (results_pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hang detector: any accepted transaction on either side resets the count.
  always @(posedge clk) begin
    if (!rst) begin
      if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)) begin
        idle_cycles = 0;
      end else if (idle_cycles == STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles++;
      end
    end
  end

  // Result side: ready follows a random 32-bit stall mask, walked bit by bit and redrawn
  // whenever its age counter runs out. Masks range from never stalling to mostly stalled. A hold
  // request from the stimulus drops ready for HOLD_CYCLES, counted here.
  initial begin
    logic [31:0] stall_mask;
    int mask_pos;
    int pattern_age;
    stall_mask = '1;
    mask_pos = 0;
    pattern_age = 0;
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        result_bus.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      if (pattern_age == 0) begin
        case ($urandom_range(0, 3))
          0: stall_mask = '1;
          1: stall_mask = $urandom;
          2: stall_mask = $urandom | $urandom;
          default: stall_mask = $urandom & $urandom;
        endcase
        if (stall_mask == '0) stall_mask = 32'h1;
        pattern_age = 64;
      end
      pattern_age--;
      result_bus.ready = stall_mask[mask_pos];
      mask_pos = (mask_pos + 1) % 32;
    end
  end

  // Offer one transaction and wait until it is taken. Transactions come in
  // bursts of random length; between bursts the sender may go quiet a while.
  task automatic offer(logic func, logic [IDX_W-1:0] idx, logic [WEIGHT_W-1:0] grad,
                       logic [WEIGHT_W-1:0] wload, logic [STEP_W-1:0] sload,
                       logic [31:0] lnow, logic [31:0] lbefore);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (sender_gaps && $urandom_range(0, 2) != 0)
        repeat ($urandom_range(1, 8)) begin
          @(negedge clk);
          item_bus.valid = 1'b0;
        end
    end
    burst_left--;
    @(negedge clk);
    item_bus.valid       = 1'b1;
    item_bus.func        = func;
    item_bus.entry_index = idx;
    item_bus.gradient    = grad;
    item_bus.load_weight = wload;
    item_bus.load_step   = sload;
    item_bus.loss_now    = lnow;
    item_bus.loss_before = lbefore;
    do @(posedge clk); while (!item_bus.ready);
    if (func == FUNC_LOAD && !entry_loaded[idx]) begin
      entry_loaded[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
    last_index = idx;
  endtask

  // Gradient and losses are don't-care on a load; fill them with noise.
  task automatic load_entry(logic [IDX_W-1:0] idx, logic [WEIGHT_W-1:0] wload,
                            logic [STEP_W-1:0] sload);
    offer(FUNC_LOAD, idx, $urandom, wload, sload, $urandom, $urandom);
  endtask

  task automatic update_entry(logic [IDX_W-1:0] idx, logic [WEIGHT_W-1:0] grad,
                              logic [31:0] lnow, logic [31:0] lbefore);
    offer(FUNC_UPDATE, idx, grad, $urandom, STEP_W'($urandom), lnow, lbefore);
  endtask

  // Stop offering and wait until every predicted result has been seen.
  task automatic drain();
    @(negedge clk);
    item_bus.valid = 1'b0;
    while (results_pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] which, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = which;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Registers change only with the engine empty.
  task automatic configure(logic [INC_W-1:0] grow, logic [DEC_W-1:0] shrink,
                           logic [STEP_W-1:0] step_lo, logic [STEP_W-1:0] step_hi);
    drain();
    write_reg(CFG_INCREASE, CFG_W'(grow));
    write_reg(CFG_DECREASE, CFG_W'(shrink));
    write_reg(CFG_STEP_MIN, CFG_W'(step_lo));
    write_reg(CFG_STEP_MAX, CFG_W'(step_hi));
  endtask

  // Random traffic. Roughly one load per six transactions; updates only touch
  // loaded entries and often repeat the previous entry, so sign runs, flips and
  // back-to-back same-entry hazards all come up.
  task automatic run_random(int count);
    logic [IDX_W-1:0]    idx;
    logic [WEIGHT_W-1:0] grad;
    logic [WEIGHT_W-1:0] wval;
    logic [STEP_W-1:0]   sval;
    logic [31:0]         lnow;
    logic [31:0]         lbefore;
    repeat (count) begin
      lbefore = $urandom;
      if (loaded_list.size() == 0 || $urandom_range(0, 99) < 15) begin
        if (loaded_list.size() == 0 || $urandom_range(0, 1) == 0)
          idx = IDX_W'($urandom_range(0, NUM_ENTRIES - 1));
        else
          idx = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
        case ($urandom_range(0, 9))
          0: wval = 32'h7FFF_FFFF - $urandom_range(0, 255);
          1: wval = 32'h8000_0000 + $urandom_range(0, 255);
          default: wval = $urandom;
        endcase
        case ($urandom_range(0, 9))
          0: sval = '0;
          1: sval = STEP_CAP;
          2, 3: sval = STEP_W'($urandom);
          default: sval = STEP_W'($urandom_range(1, 1 << 25));
        endcase
        load_entry(idx, wval, sval);
      end else begin
        if (entry_loaded[last_index] && $urandom_range(0, 9) < 3)
          idx = last_index;
        else
          idx = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
        case ($urandom_range(0, 9))
          0: grad = '0;
          1, 2, 3, 4: grad = $urandom;
          default: begin
            grad = $urandom_range(1, 1 << 24);
            if ($urandom_range(0, 1) == 1) grad = -grad;
          end
        endcase
        // about half the updates see a worse loss
        case ($urandom_range(0, 9))
          0, 1, 2, 3: lnow = lbefore + $urandom_range(1, 4096);
          4, 5, 6: lnow = lbefore - $urandom_range(1, 4096);
          7: lnow = lbefore;
          default: lnow = $urandom;
        endcase
        update_entry(idx, grad, lnow, lbefore);
      end
    end
  endtask

  initial begin
    item_bus.valid       = 1'b0;
    item_bus.func        = FUNC_UPDATE;
    item_bus.entry_index = '0;
    item_bus.gradient    = '0;
    item_bus.load_weight = '0;
    item_bus.load_step   = '0;
    item_bus.loss_now    = '0;
    item_bus.loss_before = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, reset configuration (grow 1.2, shrink 0.5, clamps 17 and 50.0).
    load_entry(10'd0, 32'h0000_0000, 31'h0100_0000);
    load_entry(10'd1023, 32'h7FFF_FFFF, STEP_CAP);
    load_entry(10'd512, 32'h8000_0000, 31'h4000_0000);
    update_entry(10'd0, 32'h0000_0001, 32'd0, 32'd0);      // no history: plain step
    update_entry(10'd0, 32'h00AB_CDEF, 32'd0, 32'd0);      // same sign: grow
    update_entry(10'd0, 32'hFFFF_FFFF, 32'd100, 32'd50);   // flip, loss worse: backtrack
    update_entry(10'd0, 32'hFFFF_FFF9, 32'd0, 32'd0);      // sign was cleared: plain step
    update_entry(10'd0, 32'hFFFF_FFF7, 32'd0, 32'd0);      // grow, negative side
    update_entry(10'd0, 32'h0000_0005, 32'd77, 32'd77);    // flip, equal loss: no backtrack
    update_entry(10'd0, 32'h0000_0000, 32'd0, 32'd0);      // zero gradient: no move
    update_entry(10'd1023, 32'h8000_0000, 32'd0, 32'd0);   // most negative grad, clips high
    update_entry(10'd1023, 32'hFFFF_FFFD, 32'd0, 32'd0);   // grow hits maximum, clips high
    update_entry(10'd512, 32'h7FFF_FFFF, 32'd0, 32'd0);    // clips low
    update_entry(10'd512, 32'h0000_0001, 32'd0, 32'd0);    // grow, clips low
    update_entry(10'd512, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0); // backtrack off the floor
    load_entry(10'd5, 32'h0000_0000, 31'd0);
    update_entry(10'd5, 32'h0000_0001, 32'd0, 32'd0);      // zero step
    update_entry(10'd5, 32'hFFFF_FFFF, 32'd9, 32'd1);      // shrink of zero lifts to minimum
    update_entry(10'd5, 32'h0000_0001, 32'd0, 32'd0);      // plain step at the minimum

    // Random part at reset values, opening with a long receiver hold-off.
    hold_request = 1'b1;
    run_random(110);

    // Extremes: fastest growth, shrink to nothing, no floor, ceiling at the cap.
    // Sender runs without gaps here.
    configure(16'hFFFF, 15'd0, 31'd0, STEP_CAP);
    sender_gaps = 1'b0;
    run_random(100);
    sender_gaps = 1'b1;

    // Unity factors, minimum above maximum: each clamp applies alone.
    configure(16'd16384, 15'd16384, STEP_CAP, 31'd0);
    run_random(80);

    // Shrink factor above one: the shrunk step can hit the cap.
    configure(INC_W'($urandom_range(0, 65535)), DEC_W'($urandom_range(16385, 32767)),
              STEP_W'($urandom_range(0, 1 << 20)), STEP_W'($urandom_range(1 << 26, STEP_CAP)));
    run_random(80);

    // Random in-range setting, second hold-off.
    configure(INC_W'($urandom_range(16384, 65535)), DEC_W'($urandom_range(0, 16384)),
              STEP_W'($urandom_range(0, 1 << 16)), STEP_W'($urandom_range(1 << 24, STEP_CAP)));
    hold_request = 1'b1;
    run_random(110);

    // Back to the reset values, written explicitly.
    configure(16'd19661, 15'd8192, 31'd17, 31'd838860800);
    run_random(60);

    // Wind down: everything predicted must have arrived, then allow time
    // for any stray result to show up.
    drain();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: filelist.f
src/irpp_pkg.sv
src/irpp_if.sv
src/irpp_store.sv
src/irpp_update.sv
src/irprop_plus_weight_update_top.sv
src/irpp_checker.sv
tb/sv/irpp_update_checker.sv
tb/sv/tb_irprop_plus_weight_update_top.sv
